/* hdl/orct_pkg.sv */
package orct_pkg;

	localparam int SECTOR_W = 16;
	localparam int COUNT_W  = 16;
	localparam int HANDLE_W = 4;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// action codes, code 3 behaves as a check
	localparam logic [1:0] ACT_OPEN  = 2'd0;
	localparam logic [1:0] ACT_CLOSE = 2'd1;
	localparam logic [1:0] ACT_CHECK = 2'd2;
	localparam logic [1:0] ACT_SPARE = 2'd3;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_ABSENT = 2'd1,
		ST_FULL   = 2'd2,
		ST_SAT    = 2'd3
	} status_t;

	// summary of one lookup across all slots
	typedef struct packed {
		logic               hit;
		logic               free_avail;
		logic [COUNT_W-1:0] hit_count;
	} lookup_t;

	// one table update, applied at the slots of the write one-hot
	typedef struct packed {
		logic                en;
		logic                set_valid;
		logic                clr_valid;
		logic [SECTOR_W-1:0] sector;
		logic [COUNT_W-1:0]  count;
	} update_t;

endpackage

/* hdl/orct_lookup.sv */
module orct_lookup #(
	parameter int ENTRIES = 16,
	parameter int IDX_W   = 4
) (
	input  logic [ENTRIES-1:0]            entry_valid,
	input  logic [orct_pkg::SECTOR_W-1:0] entry_sector [ENTRIES],
	input  logic [orct_pkg::COUNT_W-1:0]  entry_count [ENTRIES],
	input  logic [orct_pkg::SECTOR_W-1:0] sector,
	output logic [ENTRIES-1:0]            hit_oh,
	output logic [ENTRIES-1:0]            free_oh,
	output logic [IDX_W-1:0]              hit_idx,
	output logic [IDX_W-1:0]              free_idx,
	output orct_pkg::lookup_t             lkp
);
	import orct_pkg::*;

	logic [ENTRIES-1:0] match;
	logic [ENTRIES-1:0] free_vec;

	// lowest set bit isolates the winning slot
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = entry_valid[i] && (entry_sector[i] == sector);
		end
		free_vec = ~entry_valid;
		hit_oh   = match & (~match + {{(ENTRIES-1){1'b0}}, 1'b1});
		free_oh  = free_vec & (~free_vec + {{(ENTRIES-1){1'b0}}, 1'b1});
	end

	always_comb begin
		hit_idx       = '0;
		free_idx      = '0;
		lkp.hit_count = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (hit_oh[i]) begin
				hit_idx       = hit_idx | IDX_W'(i);
				lkp.hit_count = lkp.hit_count | entry_count[i];
			end
			if (free_oh[i]) begin
				free_idx = free_idx | IDX_W'(i);
			end
		end
		lkp.hit        = |match;
		lkp.free_avail = |free_vec;
	end

endmodule

/* hdl/orct_store.sv */
module orct_store #(
	parameter int ENTRIES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ENTRIES-1:0]            wr_oh,
	input  orct_pkg::update_t             upd,
	output logic [ENTRIES-1:0]            entry_valid,
	output logic [orct_pkg::SECTOR_W-1:0] entry_sector [ENTRIES],
	output logic [orct_pkg::COUNT_W-1:0]  entry_count [ENTRIES]
);
	import orct_pkg::*;

	logic [ENTRIES-1:0]  valid_q;
	logic [SECTOR_W-1:0] sector_q [ENTRIES];
	logic [COUNT_W-1:0]  count_q [ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (upd.en) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (wr_oh[i] && upd.set_valid) begin
					valid_q[i] <= 1'b1;
				end else if (wr_oh[i] && upd.clr_valid) begin
					valid_q[i] <= 1'b0;
				end
			end
		end
	end

	// payload storage, only read behind a valid bit
	always_ff @(posedge clk) begin
		if (upd.en) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (wr_oh[i]) begin
					count_q[i] <= upd.count;
					if (upd.set_valid) begin
						sector_q[i] <= upd.sector;
					end
				end
			end
		end
	end

	assign entry_valid  = valid_q;
	assign entry_sector = sector_q;
	assign entry_count  = count_q;

endmodule

/* hdl/open_refcount_table_top.sv */
// open reference count table, keyed by a 16-bit sector number
//
// request channel: drive action and sector with start high; the transfer
// happens at a rising edge where start is high and busy is low. busy is
// never raised, so a request may be issued in every cycle.
// result channel: done is high for exactly one cycle with handle,
// open_count, removable and status; the receiver cannot stall, so the
// result must be taken in that cycle.
// done is raised once the request has passed the input register and then
// the result register. throughput: one request per cycle, set by the
// combinational parallel compare over all slots and the read-modify-write
// of the slot registers that sits between the two registers.
// back-to-back requests on the same sector see each other's update
// because the table is written at the same edge that loads the result.
// reset: all slots are freed at once (valid bits cleared), pending
// requests are dropped and done is low.
// handle carries the low four bits of the slot index.
module open_refcount_table_top #(
	parameter int ENTRIES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    action,
	input  logic [orct_pkg::SECTOR_W-1:0] sector,
	output logic                          done,
	output logic [orct_pkg::HANDLE_W-1:0] handle,
	output logic [orct_pkg::COUNT_W-1:0]  open_count,
	output logic                          removable,
	output logic [1:0]                    status
);
	import orct_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	// input register
	logic                valid_s1;
	logic [1:0]          action_s1;
	logic [SECTOR_W-1:0] sector_s1;

	// table view
	logic [ENTRIES-1:0]  entry_valid;
	logic [SECTOR_W-1:0] entry_sector [ENTRIES];
	logic [COUNT_W-1:0]  entry_count [ENTRIES];

	logic [ENTRIES-1:0] hit_oh;
	logic [ENTRIES-1:0] free_oh;
	logic [IDX_W-1:0]   hit_idx;
	logic [IDX_W-1:0]   free_idx;
	lookup_t            lkp;

	update_t            upd;
	logic [ENTRIES-1:0] wr_oh;

	// next result
	logic [HANDLE_W-1:0] res_handle;
	logic [COUNT_W-1:0]  res_count;
	logic                res_removable;
	status_t             res_status;

	// result register
	logic                done_s2;
	logic [HANDLE_W-1:0] handle_s2;
	logic [COUNT_W-1:0]  count_s2;
	logic                removable_s2;
	status_t             status_s2;

	// every request finishes in one pass, nothing ever holds the input off
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			action_s1 <= action;
			sector_s1 <= sector;
		end
	end

	orct_lookup #(
		.ENTRIES(ENTRIES),
		.IDX_W  (IDX_W)
	) u_lookup (
		.entry_valid (entry_valid),
		.entry_sector(entry_sector),
		.entry_count (entry_count),
		.sector      (sector_s1),
		.hit_oh      (hit_oh),
		.free_oh     (free_oh),
		.hit_idx     (hit_idx),
		.free_idx    (free_idx),
		.lkp         (lkp)
	);

	// action decode and the read-modify-write of one slot
	always_comb begin
		upd           = '0;
		upd.sector    = sector_s1;
		wr_oh         = hit_oh;
		res_handle    = '0;
		res_count     = '0;
		res_removable = 1'b1;
		res_status    = ST_OK;
		unique case (action_s1)
			ACT_OPEN: begin
				if (lkp.hit) begin
					// count saturates at its maximum
					upd.en        = valid_s1;
					res_handle    = HANDLE_W'(hit_idx);
					res_removable = 1'b0;
					if (lkp.hit_count == COUNT_MAX) begin
						upd.count  = COUNT_MAX;
						res_status = ST_SAT;
					end else begin
						upd.count = lkp.hit_count + COUNT_W'(1);
					end
					res_count = upd.count;
				end else if (lkp.free_avail) begin
					// claim the lowest free slot
					upd.en        = valid_s1;
					upd.set_valid = 1'b1;
					upd.count     = COUNT_W'(1);
					wr_oh         = free_oh;
					res_handle    = HANDLE_W'(free_idx);
					res_count     = COUNT_W'(1);
					res_removable = 1'b0;
				end else begin
					res_status = ST_FULL;
				end
			end
			ACT_CLOSE: begin
				if (!lkp.hit) begin
					res_status = ST_ABSENT;
				end else if (lkp.hit_count > COUNT_W'(1)) begin
					upd.en        = valid_s1;
					upd.count     = lkp.hit_count - COUNT_W'(1);
					res_handle    = HANDLE_W'(hit_idx);
					res_count     = upd.count;
					res_removable = 1'b0;
				end else begin
					// last close frees the slot
					upd.en        = valid_s1;
					upd.clr_valid = 1'b1;
					upd.count     = '0;
					res_handle    = HANDLE_W'(hit_idx);
				end
			end
			default: begin
				// check, and the unused code behaves the same
				if (lkp.hit) begin
					res_handle    = HANDLE_W'(hit_idx);
					res_count     = lkp.hit_count;
					res_removable = 1'b0;
				end
			end
		endcase
	end

	orct_store #(
		.ENTRIES(ENTRIES)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_oh       (wr_oh),
		.upd         (upd),
		.entry_valid (entry_valid),
		.entry_sector(entry_sector),
		.entry_count (entry_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			handle_s2    <= res_handle;
			count_s2     <= res_count;
			removable_s2 <= res_removable;
			status_s2    <= res_status;
		end
	end

	assign done       = done_s2;
	assign handle     = handle_s2;
	assign open_count = count_s2;
	assign removable  = removable_s2;
	assign status     = status_s2;

	// each request in the input register yields a result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("request lost between input and result register");

	// a removable result never reports a live count
	a_removable_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && removable |-> open_count == '0)
		else $error("removable result with nonzero count");

	// table full is only reported when every slot was in use
	a_full_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_FULL |-> $past(&entry_valid))
		else $error("table full reported with a free slot");

	// an open that succeeds always leaves a live entry
	a_open_live: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && action_s1 == ACT_OPEN && res_status != ST_FULL
		|-> !res_removable && res_count != '0)
		else $error("open left no live entry");

endmodule
